### hdl/channel_frame_deframer_macros.svh
// Assertion macros for the deframer RTL, included by cfd_back.
`ifndef CHANNEL_FRAME_DEFRAMER_MACROS_SVH
`define CHANNEL_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

`define CFD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("cfd assertion failed");

`define CFD_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("cfd forbidden condition seen");

`else

`define CFD_ASSERT(lbl, clk, rst_n, prop)

`define CFD_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### hdl/cfd_pkg.sv
// Shared types, widths and constants of the channel frame deframer.
`timescale 1ns / 1ps

package cfd_pkg;

    localparam int KIND_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int TIME_W   = 32;
    localparam int CLIENT_W = 32;
    localparam int IDX_W    = 4;
    localparam int WORD_W   = 16;
    localparam int CFG_W    = 16;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam int NUM_CHANNELS_DEF = 16;
    localparam int MAX_RESULTS      = 16;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [BYTE_W-1:0] HDR_BYTE = 8'h3E;
    localparam logic [BYTE_W-1:0] FTR_BYTE = 8'h23;

    localparam logic [CFG_W-1:0] STALL_MS_RST    = 16'd500;
    localparam logic [CFG_W-1:0] ACK_INT_MS_RST  = 16'd100;
    localparam logic [CFG_W-1:0] FS_TIMEOUT_RST  = 16'd2000;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA       = 2'd0,
        KIND_CONNECT    = 2'd1,
        KIND_DISCONNECT = 2'd2,
        KIND_TICK       = 2'd3
    } t_kind;

    typedef enum logic [KIND_W-1:0] {
        RES_WORD = 2'd0,
        RES_ACK  = 2'd1,
        RES_FAIL = 2'd2
    } t_res_kind;

    typedef enum logic [1:0] {
        REG_STALL   = 2'd0,
        REG_ACK_INT = 2'd1,
        REG_FS_TO   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] stall_ms;
        logic [CFG_W-1:0] ack_int_ms;
        logic [CFG_W-1:0] fs_to_ms;
    } t_cfg;

    typedef struct packed {
        logic                do_frame;
        logic                do_ack;
        logic [CLIENT_W-1:0] ack_client;
        logic                do_fs;
        logic                fs_hold;
    } t_cmd;

endpackage

### hdl/cfd_ifs.sv
// Input and result word channels of the deframer.
`timescale 1ns / 1ps

interface cfd_in_if;
    logic                          valid;
    logic                          ready;
    logic [cfd_pkg::KIND_W-1:0]    kind;
    logic [cfd_pkg::BYTE_W-1:0]    data_byte;
    logic                          first_in_payload;
    logic [cfd_pkg::TIME_W-1:0]    now_ms;
    logic [cfd_pkg::CLIENT_W-1:0]  client_id;
    logic                          tx_ready;

    modport source (
        output valid, kind, data_byte, first_in_payload, now_ms, client_id, tx_ready,
        input  ready
    );
    modport sink (
        input  valid, kind, data_byte, first_in_payload, now_ms, client_id, tx_ready,
        output ready
    );
endinterface

interface cfd_out_if;
    logic                          valid;
    logic                          ready;
    logic [cfd_pkg::KIND_W-1:0]    result_kind;
    logic [cfd_pkg::IDX_W-1:0]     channel_index;
    logic [cfd_pkg::WORD_W-1:0]    channel_value;
    logic [cfd_pkg::CLIENT_W-1:0]  ack_client;
    logic                          failsafe_hold;
    logic                          last;

    modport source (
        output valid, result_kind, channel_index, channel_value, ack_client,
               failsafe_hold, last,
        input  ready
    );
    modport sink (
        input  valid, result_kind, channel_index, channel_value, ack_client,
               failsafe_hold, last,
        output ready
    );
endinterface

### hdl/cfd_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module cfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/cfd_queue.sv
// Short command queue between the front end and the result sequencer.
`timescale 1ns / 1ps

module cfd_queue #(
    parameter int DEPTH = cfd_pkg::QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cfd_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output cfd_pkg::t_cmd o_data
);

    cfd_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        f_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= f_next(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= f_next(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

### hdl/cfd_front.sv
// Front end: takes input words, tracks frame and timing state, queues result commands.
`timescale 1ns / 1ps

module cfd_front #(
    parameter int NUM_CHANNELS = cfd_pkg::NUM_CHANNELS_DEF,
    localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    cfd_in_if.sink                       i_in,
    input  cfd_pkg::t_cfg                i_cfg,
    input  logic                         i_q_full,
    output logic                         o_push,
    output cfd_pkg::t_cmd                o_cmd,
    input  logic                         i_frame_done,
    output logic                         o_ram_we,
    output logic [ADDR_W-1:0]            o_ram_waddr,
    output logic [2*cfd_pkg::BYTE_W-1:0] o_ram_wdata
);

    localparam int PAYLOAD_LEN = 2 * NUM_CHANNELS;
    localparam int CNT_W       = $clog2(PAYLOAD_LEN + 1);

    logic [CNT_W-1:0]             r_byte_count, n_byte_count;
    logic                         r_in_frame, n_in_frame;
    logic [cfd_pkg::TIME_W-1:0]   r_last_good, n_last_good;
    logic [cfd_pkg::TIME_W-1:0]   r_last_ack, n_last_ack;
    logic                         r_ack_pending, n_ack_pending;
    logic [cfd_pkg::CLIENT_W-1:0] r_ack_target, n_ack_target;
    logic                         r_link_started, n_link_started;
    logic                         r_good_seen, n_good_seen;
    logic                         r_frame_busy, n_frame_busy;
    logic [cfd_pkg::BYTE_W-1:0]   r_lo_byte;

    logic                         accept;
    logic [cfd_pkg::TIME_W-1:0]   good_age;
    logic [cfd_pkg::TIME_W-1:0]   ack_age;
    logic                         stall;
    logic                         in_frame_eff;
    logic [CNT_W-1:0]             cnt_eff;
    logic                         ack_fire;
    logic                         fs_fire;
    logic                         lo_we;

    assign i_in.ready = !i_q_full && !r_frame_busy;
    assign accept     = i_in.valid && i_in.ready;

    assign good_age = i_in.now_ms - r_last_good;
    assign ack_age  = i_in.now_ms - r_last_ack;

    // stale half-built frame is dropped on the first byte of a payload
    assign stall = i_in.first_in_payload && r_good_seen &&
                   (good_age >= cfd_pkg::TIME_W'(i_cfg.stall_ms));
    assign in_frame_eff = r_in_frame && !stall;
    assign cnt_eff      = stall ? '0 : r_byte_count;

    assign ack_fire = r_ack_pending && i_in.tx_ready &&
                      (ack_age >= cfd_pkg::TIME_W'(i_cfg.ack_int_ms));
    assign fs_fire  = r_good_seen &&
                      (good_age >= cfd_pkg::TIME_W'(i_cfg.fs_to_ms));

    assign o_ram_waddr = ADDR_W'(cnt_eff >> 1);
    assign o_ram_wdata = {i_in.data_byte, r_lo_byte};

    always_comb begin
        n_byte_count   = r_byte_count;
        n_in_frame     = r_in_frame;
        n_last_good    = r_last_good;
        n_last_ack     = r_last_ack;
        n_ack_pending  = r_ack_pending;
        n_ack_target   = r_ack_target;
        n_link_started = r_link_started;
        n_good_seen    = r_good_seen;
        n_frame_busy   = r_frame_busy;
        o_push         = 1'b0;
        o_cmd          = '0;
        o_ram_we       = 1'b0;
        lo_we          = 1'b0;

        if (i_frame_done) begin
            n_frame_busy = 1'b0;
        end

        if (accept) begin
            case (cfd_pkg::t_kind'(i_in.kind))
                cfd_pkg::KIND_DATA: begin
                    n_byte_count = cnt_eff;
                    n_in_frame   = in_frame_eff;
                    if (!in_frame_eff) begin
                        if (i_in.data_byte == cfd_pkg::HDR_BYTE) begin
                            n_byte_count = '0;
                            n_in_frame   = 1'b1;
                        end
                    end else if (cnt_eff == CNT_W'(PAYLOAD_LEN)) begin
                        if (i_in.data_byte == cfd_pkg::FTR_BYTE) begin
                            o_push         = 1'b1;
                            o_cmd.do_frame = 1'b1;
                            n_frame_busy   = 1'b1;
                            n_last_good    = i_in.now_ms;
                            n_good_seen    = 1'b1;
                            n_ack_target   = i_in.client_id;
                            n_ack_pending  = 1'b1;
                        end
                        n_byte_count = '0;
                        n_in_frame   = 1'b0;
                    end else begin
                        lo_we        = !cnt_eff[0];
                        o_ram_we     = cnt_eff[0];
                        n_byte_count = cnt_eff + 1'b1;
                    end
                end
                cfd_pkg::KIND_CONNECT: begin
                    n_byte_count   = '0;
                    n_in_frame     = 1'b0;
                    n_link_started = 1'b1;
                end
                cfd_pkg::KIND_DISCONNECT: begin
                    n_byte_count = '0;
                    n_in_frame   = 1'b0;
                    if (r_ack_pending && (r_ack_target == i_in.client_id)) begin
                        n_ack_pending = 1'b0;
                    end
                    o_push        = 1'b1;
                    o_cmd.do_fs   = 1'b1;
                    o_cmd.fs_hold = 1'b1;
                end
                cfd_pkg::KIND_TICK: begin
                    if (ack_fire) begin
                        n_last_ack    = i_in.now_ms;
                        n_ack_pending = 1'b0;
                    end
                    o_push           = ack_fire || fs_fire;
                    o_cmd.do_ack     = ack_fire;
                    o_cmd.ack_client = r_ack_target;
                    o_cmd.do_fs      = fs_fire;
                    o_cmd.fs_hold    = !r_link_started;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count   <= '0;
            r_in_frame     <= 1'b0;
            r_last_good    <= '0;
            r_last_ack     <= '0;
            r_ack_pending  <= 1'b0;
            r_ack_target   <= '0;
            r_link_started <= 1'b0;
            r_good_seen    <= 1'b0;
            r_frame_busy   <= 1'b0;
        end else begin
            r_byte_count   <= n_byte_count;
            r_in_frame     <= n_in_frame;
            r_last_good    <= n_last_good;
            r_last_ack     <= n_last_ack;
            r_ack_pending  <= n_ack_pending;
            r_ack_target   <= n_ack_target;
            r_link_started <= n_link_started;
            r_good_seen    <= n_good_seen;
            r_frame_busy   <= n_frame_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lo_we) begin
            r_lo_byte <= i_in.data_byte;
        end
    end

endmodule

### hdl/cfd_back.sv
// Result sequencer: expands queued commands into result words.
`timescale 1ns / 1ps
`include "channel_frame_deframer_macros.svh"

module cfd_back #(
    parameter int NUM_CHANNELS = cfd_pkg::NUM_CHANNELS_DEF,
    localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_empty,
    input  cfd_pkg::t_cmd                i_q_data,
    output logic                         o_pop,
    output logic [ADDR_W-1:0]            o_raddr,
    input  logic [2*cfd_pkg::BYTE_W-1:0] i_rdata,
    output logic                         o_frame_done,
    cfd_out_if.source                    o_out
);

    localparam int LIM = (NUM_CHANNELS < cfd_pkg::MAX_RESULTS) ?
                         NUM_CHANNELS : cfd_pkg::MAX_RESULTS;
    localparam logic [ADDR_W-1:0] LAST_CH = ADDR_W'(LIM - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WORDS = 4'b0010,
        S_ACK   = 4'b0100,
        S_FAIL  = 4'b1000
    } t_bstate;

    t_bstate                      r_state, n_state;
    cfd_pkg::t_cmd                r_cmd, n_cmd;
    logic [ADDR_W-1:0]            r_ch, n_ch;

    logic                         r_o_valid;
    cfd_pkg::t_res_kind           r_o_kind;
    logic [cfd_pkg::IDX_W-1:0]    r_o_idx;
    logic [cfd_pkg::WORD_W-1:0]   r_o_val;
    logic [cfd_pkg::CLIENT_W-1:0] r_o_client;
    logic                         r_o_hold;
    logic                         r_o_last;

    logic                         out_free;
    logic                         load;
    cfd_pkg::t_res_kind           ld_kind;
    logic [cfd_pkg::IDX_W-1:0]    ld_idx;
    logic [cfd_pkg::WORD_W-1:0]   ld_val;
    logic [cfd_pkg::CLIENT_W-1:0] ld_client;
    logic                         ld_hold;
    logic                         ld_last;

    assign out_free = !r_o_valid || o_out.ready;

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_ch         = r_ch;
        o_pop        = 1'b0;
        o_frame_done = 1'b0;
        o_raddr      = r_ch;
        load         = 1'b0;
        ld_kind      = cfd_pkg::RES_WORD;
        ld_idx       = '0;
        ld_val       = '0;
        ld_client    = '0;
        ld_hold      = 1'b0;
        ld_last      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_q_data;
                    n_ch    = '0;
                    o_raddr = '0;
                    if (i_q_data.do_frame) begin
                        n_state = S_WORDS;
                    end else if (i_q_data.do_ack) begin
                        n_state = S_ACK;
                    end else begin
                        n_state = S_FAIL;
                    end
                end
            end
            S_WORDS: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_kind = cfd_pkg::RES_WORD;
                    ld_idx  = cfd_pkg::IDX_W'(r_ch);
                    ld_val  = i_rdata;
                    o_raddr = r_ch + 1'b1;
                    if (r_ch == LAST_CH) begin
                        o_frame_done = 1'b1;
                        ld_last      = !(r_cmd.do_ack || r_cmd.do_fs);
                        if (r_cmd.do_ack) begin
                            n_state = S_ACK;
                        end else if (r_cmd.do_fs) begin
                            n_state = S_FAIL;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_ch = r_ch + 1'b1;
                    end
                end
            end
            S_ACK: begin
                if (out_free) begin
                    load      = 1'b1;
                    ld_kind   = cfd_pkg::RES_ACK;
                    ld_client = r_cmd.ack_client;
                    ld_last   = !r_cmd.do_fs;
                    n_state   = r_cmd.do_fs ? S_FAIL : S_IDLE;
                end
            end
            S_FAIL: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_kind = cfd_pkg::RES_FAIL;
                    ld_hold = r_cmd.fs_hold;
                    ld_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ch      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            if (out_free) begin
                r_o_valid <= load;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (out_free && load) begin
            r_o_kind   <= ld_kind;
            r_o_idx    <= ld_idx;
            r_o_val    <= ld_val;
            r_o_client <= ld_client;
            r_o_hold   <= ld_hold;
            r_o_last   <= ld_last;
        end
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.result_kind   = r_o_kind;
    assign o_out.channel_index = r_o_idx;
    assign o_out.channel_value = r_o_val;
    assign o_out.ack_client    = r_o_client;
    assign o_out.failsafe_hold = r_o_hold;
    assign o_out.last          = r_o_last;

    `CFD_ASSERT(a_pop_when_idle, i_clk, i_rst_n, o_pop |-> (r_state == S_IDLE))
    `CFD_ASSERT(a_words_need_frame, i_clk, i_rst_n, (r_state == S_WORDS) |-> r_cmd.do_frame)
    `CFD_ASSERT(a_done_shows_last_word, i_clk, i_rst_n, o_frame_done |=> (o_out.valid && (o_out.result_kind == cfd_pkg::RES_WORD) && (o_out.channel_index == cfd_pkg::IDX_W'(LIM - 1))))
    `CFD_NEVER(a_no_pop_when_empty, i_clk, i_rst_n, o_pop && i_q_empty)

endmodule

### hdl/channel_frame_deframer.sv
// Top level of the channel frame deframer with its register port.
`timescale 1ns / 1ps

// Takes one input word per cycle while i_in.ready is high (data byte, connect,
// disconnect or tick) and produces channel, acknowledgement and failsafe
// results on o_out, each result set closed by last. Connect and ignored bytes
// give no result. A good '#' footer queues a frame release; the input then
// waits until the sequencer has moved all min(NUM_CHANNELS, 16) channel words
// into the output register, one word per cycle read from the frame RAM while
// o_out.ready lets the output register take it. The sequencer takes a command
// from the queue while idle, then loads its results in turn, each when the
// output register is free. A queue of QUEUE_DEPTH commands sits between the
// front end and the sequencer, so outside the frame hold input keeps flowing
// while results wait on o_out.ready until the queue is full. Registers at byte
// addresses 0, 4 and 8: stall reset, acknowledgement interval and failsafe
// timeout, in milliseconds; write them only while the block is idle.
module channel_frame_deframer #(
    parameter int NUM_CHANNELS = cfd_pkg::NUM_CHANNELS_DEF,
    parameter int QUEUE_DEPTH  = cfd_pkg::QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    cfd_in_if.sink                       i_in,
    cfd_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cfd_pkg::PADDR_W-1:0]  paddr,
    input  logic [cfd_pkg::PDATA_W-1:0]  pwdata,
    output logic [cfd_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    cfd_pkg::t_cfg                r_cfg;
    cfd_pkg::t_reg_idx            reg_sel;
    logic                         wr_en;

    logic                         q_full;
    logic                         q_empty;
    logic                         q_push;
    logic                         q_pop;
    cfd_pkg::t_cmd                q_in;
    cfd_pkg::t_cmd                q_out;
    logic                         frame_done;
    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_waddr;
    logic [2*cfd_pkg::BYTE_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]            ram_raddr;
    logic [2*cfd_pkg::BYTE_W-1:0] ram_rdata;

    assign pready  = 1'b1;
    assign reg_sel = cfd_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stall_ms   <= cfd_pkg::STALL_MS_RST;
            r_cfg.ack_int_ms <= cfd_pkg::ACK_INT_MS_RST;
            r_cfg.fs_to_ms   <= cfd_pkg::FS_TIMEOUT_RST;
        end else if (wr_en) begin
            case (reg_sel)
                cfd_pkg::REG_STALL:   r_cfg.stall_ms   <= pwdata[cfd_pkg::CFG_W-1:0];
                cfd_pkg::REG_ACK_INT: r_cfg.ack_int_ms <= pwdata[cfd_pkg::CFG_W-1:0];
                cfd_pkg::REG_FS_TO:   r_cfg.fs_to_ms   <= pwdata[cfd_pkg::CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            cfd_pkg::REG_STALL:   prdata = cfd_pkg::PDATA_W'(r_cfg.stall_ms);
            cfd_pkg::REG_ACK_INT: prdata = cfd_pkg::PDATA_W'(r_cfg.ack_int_ms);
            cfd_pkg::REG_FS_TO:   prdata = cfd_pkg::PDATA_W'(r_cfg.fs_to_ms);
            default:              prdata = '0;
        endcase
    end

    cfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    cfd_ram #(
        .WIDTH (2 * cfd_pkg::BYTE_W),
        .DEPTH (NUM_CHANNELS)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cfd_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (r_cfg),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_cmd        (q_in),
        .i_frame_done (frame_done),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata)
    );

    cfd_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_data     (q_out),
        .o_pop        (q_pop),
        .o_raddr      (ram_raddr),
        .i_rdata      (ram_rdata),
        .o_frame_done (frame_done),
        .o_out        (o_out)
    );

endmodule
